### src/assert_macros.svh
// assertion macros shared by the edge colour run mask rtl
// no dependencies; included by the modules that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge, masked while reset is high
`define ECRM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define ECRM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/ecrm_pkg.sv
// shared types and constants of the edge colour run mask
// no dependencies; imported by every module of the block but ecrm_ram
`default_nettype none

package ecrm_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  // input field widths
  localparam int FUNC_W  = 2;
  localparam int PIXEL_W = 32;
  localparam int COORD_W = 10;
  localparam int MASK_W  = 8;

  localparam int S_TDATA_W = 56;
  localparam int M_TDATA_W = 8;

  // table address and entry widths
  localparam int COL_AW = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int ROW_AW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int COLF_W = $clog2(MAX_WIDTH + 1);
  localparam int ROWF_W = $clog2(MAX_HEIGHT + 1);

  // clearing sweep covers the deeper table
  localparam int SWEEP_DEPTH = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SWEEP_W = (SWEEP_DEPTH > 1) ? $clog2(SWEEP_DEPTH) : 1;

  // queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_PW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic [MASK_W-1:0] MASK_OPAQUE = 8'd255;
  localparam logic [MASK_W-1:0] MASK_CLEAR  = 8'd0;

  // function codes on the input stream
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

  // configuration register indexes
  localparam logic REG_KEY_COLOR     = 1'b0;
  localparam logic REG_CHANNEL_COUNT = 1'b1;

  localparam int CH_CNT_W = 3;
  localparam logic [CH_CNT_W-1:0] CH_CNT_RESET = 3'd3;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_LOAD,
    OP_QUERY
  } op_t;

  // one classified request on its way to the back end
  typedef struct packed {
    op_t                op;
    logic               in_frame;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } req_t;

  // row table entry: bounds along the row, indexed by row
  typedef struct packed {
    logic [COL_AW-1:0] last;
    logic [COLF_W-1:0] first;
  } row_entry_t;

  // column table entry: bounds along the column, indexed by column
  typedef struct packed {
    logic [ROW_AW-1:0] last;
    logic [ROWF_W-1:0] first;
  } col_entry_t;

endpackage

`default_nettype wire

### src/ecrm_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none

module ecrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    we,
  input  wire logic [AW-1:0]           waddr,
  input  wire logic [WIDTH-1:0]        wdata,
  input  wire logic [AW-1:0]           raddr,
  output logic      [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### src/ecrm_front.sv
// front end: configuration registers, request decode and key compare
// depends on ecrm_pkg; feeds ecrm_queue
`default_nettype none

module ecrm_front import ecrm_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic                   cfg_index,
  input  wire logic [PIXEL_W-1:0]     cfg_data,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [S_TDATA_W-1:0]   s_tdata,
  input  wire logic [FUNC_W-1:0]      s_tuser,
  input  wire logic                   hold,
  input  wire logic                   q_full,
  output logic                        q_push,
  output req_t                        q_req
);

  logic [PIXEL_W-1:0]  key_color;
  logic [CH_CNT_W-1:0] channel_count;

  logic [PIXEL_W-1:0] pixel;
  logic [COORD_W-1:0] col;
  logic [COORD_W-1:0] row;
  logic               in_frame;
  logic               miss;
  logic               keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_color     <= '0;
      channel_count <= CH_CNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_COLOR:     key_color     <= cfg_data;
        REG_CHANNEL_COUNT: channel_count <= cfg_data[CH_CNT_W-1:0];
      endcase
    end
  end

  assign pixel = s_tdata[PIXEL_W-1:0];
  assign col   = s_tdata[PIXEL_W +: COORD_W];
  assign row   = s_tdata[PIXEL_W+COORD_W +: COORD_W];

  assign in_frame = ({1'b0, col} < (COORD_W+1)'(MAX_WIDTH)) &&
                    ({1'b0, row} < (COORD_W+1)'(MAX_HEIGHT));

  // channel i takes part when channel_count exceeds i
  always_comb begin
    miss = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if ((channel_count > CH_CNT_W'(i)) &&
          (pixel[8*i +: 8] != key_color[8*i +: 8])) begin
        miss = 1'b1;
      end
    end
  end

  always_comb begin
    q_req.col      = col;
    q_req.row      = row;
    q_req.in_frame = in_frame;
    q_req.op       = OP_QUERY;
    keep           = 1'b0;
    unique case (s_tuser)
      FUNC_CLEAR: begin
        q_req.op = OP_CLEAR;
        keep     = 1'b1;
      end
      FUNC_LOAD: begin
        // loads matching the key or off the frame change nothing
        q_req.op = OP_LOAD;
        keep     = in_frame && miss;
      end
      FUNC_QUERY: begin
        q_req.op = OP_QUERY;
        keep     = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign s_tready = !q_full && !hold;
  assign q_push   = s_tvalid && s_tready && keep;

endmodule

`default_nettype wire

### src/ecrm_queue.sv
// short request queue between front and back end
// depends on ecrm_pkg
`default_nettype none
`include "assert_macros.svh"

module ecrm_queue import ecrm_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  req_t      push_req,
  output logic      full,
  input  wire logic pop,
  output logic      head_valid,
  output req_t      head_req
);

  req_t              slots [Q_DEPTH];
  logic [Q_PW-1:0]   wr_ptr;
  logic [Q_PW-1:0]   rd_ptr;
  logic [Q_CW-1:0]   count;

  function automatic logic [Q_PW-1:0] ptr_inc(input logic [Q_PW-1:0] p);
    if (p == Q_PW'(Q_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign full       = (count == Q_CW'(Q_DEPTH));
  assign head_valid = (count != '0);
  assign head_req   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `ECRM_ASSERT(a_no_overflow, clk, rst, push |-> !full, "queue push while full")
  `ECRM_ASSERT(a_no_underflow, clk, rst, pop |-> head_valid, "queue pop while empty")
  `ECRM_ASSERT(a_full_ptrs, clk, rst, full |-> (wr_ptr == rd_ptr), "queue pointers disagree with count")

endmodule

`default_nettype wire

### src/ecrm_back.sv
// back end: clearing sweep, table read-modify-write and query result
// depends on ecrm_pkg and ecrm_ram; pulls from ecrm_queue
`default_nettype none
`include "assert_macros.svh"

module ecrm_back import ecrm_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 head_valid,
  input  req_t                      head_req,
  output logic                      pop,
  output logic                      sweeping,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t             state;
  logic [SWEEP_W-1:0] sweep_cnt;
  req_t               work;
  logic               out_valid;
  logic [MASK_W-1:0]  out_data;

  logic [ROW_AW-1:0]  row_raddr;
  logic [COL_AW-1:0]  col_raddr;
  logic [ROW_AW-1:0]  row_waddr;
  logic [COL_AW-1:0]  col_waddr;
  logic               row_we;
  logic               col_we;
  row_entry_t         row_rdata;
  col_entry_t         col_rdata;
  row_entry_t         row_wdata;
  col_entry_t         col_wdata;

  logic [COL_AW-1:0]  c_addr;
  logic [ROW_AW-1:0]  r_addr;
  logic [COLF_W-1:0]  c_ext;
  logic [ROWF_W-1:0]  r_ext;
  logic               outside_run;
  logic [MASK_W-1:0]  query_mask;
  logic               out_free;
  logic               sweep_last;

  row_entry_t         row_upd;
  col_entry_t         col_upd;
  row_entry_t         row_init;
  col_entry_t         col_init;

  assign row_init.first = COLF_W'(MAX_WIDTH);
  assign row_init.last  = '0;
  assign col_init.first = ROWF_W'(MAX_HEIGHT);
  assign col_init.last  = '0;

  ecrm_ram #(.WIDTH($bits(row_entry_t)), .DEPTH(MAX_HEIGHT)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .raddr (row_raddr),
    .rdata (row_rdata)
  );

  ecrm_ram #(.WIDTH($bits(col_entry_t)), .DEPTH(MAX_WIDTH)) u_col_ram (
    .clk   (clk),
    .we    (col_we),
    .waddr (col_waddr),
    .wdata (col_wdata),
    .raddr (col_raddr),
    .rdata (col_rdata)
  );

  assign pop      = (state == ST_IDLE) && head_valid;
  assign sweeping = (state == ST_SWEEP);
  assign out_free = !out_valid || m_tready;

  // read at the head while idle, hold the working address while executing
  always_comb begin
    if (state == ST_IDLE) begin
      row_raddr = ROW_AW'(head_req.row);
      col_raddr = COL_AW'(head_req.col);
    end else begin
      row_raddr = ROW_AW'(work.row);
      col_raddr = COL_AW'(work.col);
    end
  end

  assign c_addr = COL_AW'(work.col);
  assign r_addr = ROW_AW'(work.row);
  assign c_ext  = COLF_W'(c_addr);
  assign r_ext  = ROWF_W'(r_addr);

  always_comb begin
    row_upd.first = (c_ext < row_rdata.first) ? c_ext : row_rdata.first;
    row_upd.last  = (c_addr > row_rdata.last) ? c_addr : row_rdata.last;
    col_upd.first = (r_ext < col_rdata.first) ? r_ext : col_rdata.first;
    col_upd.last  = (r_addr > col_rdata.last) ? r_addr : col_rdata.last;
  end

  // transparent when the pixel lies before the first or after the last miss
  assign outside_run = (c_ext < row_rdata.first) || (c_addr > row_rdata.last) ||
                       (r_ext < col_rdata.first) || (r_addr > col_rdata.last);
  assign query_mask  = (work.in_frame && outside_run) ? MASK_CLEAR : MASK_OPAQUE;

  assign sweep_last = (sweep_cnt == SWEEP_W'(SWEEP_DEPTH - 1));

  always_comb begin
    row_we    = 1'b0;
    col_we    = 1'b0;
    row_waddr = r_addr;
    col_waddr = c_addr;
    row_wdata = row_upd;
    col_wdata = col_upd;
    unique case (state)
      ST_SWEEP: begin
        row_waddr = ROW_AW'(sweep_cnt);
        col_waddr = COL_AW'(sweep_cnt);
        row_wdata = row_init;
        col_wdata = col_init;
        row_we    = ({1'b0, sweep_cnt} < (SWEEP_W+1)'(MAX_HEIGHT));
        col_we    = ({1'b0, sweep_cnt} < (SWEEP_W+1)'(MAX_WIDTH));
      end
      ST_EXEC: begin
        row_we = (work.op == OP_LOAD);
        col_we = (work.op == OP_LOAD);
      end
      default: begin
        row_we = 1'b0;
        col_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_SWEEP;
      sweep_cnt <= '0;
      out_valid <= 1'b0;
    end else begin
      // a new result takes the output register as the old one leaves
      if (state == ST_EXEC && work.op == OP_QUERY && out_free) begin
        out_valid <= 1'b1;
        out_data  <= query_mask;
      end else if (out_valid && m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_SWEEP: begin
          sweep_cnt <= sweep_cnt + 1'b1;
          if (sweep_last) begin
            sweep_cnt <= '0;
            state     <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (head_valid) begin
            work <= head_req;
            if (head_req.op == OP_CLEAR) begin
              sweep_cnt <= '0;
              state     <= ST_SWEEP;
            end else begin
              state <= ST_EXEC;
            end
          end
        end
        ST_EXEC: begin
          if (work.op != OP_QUERY || out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = M_TDATA_W'(out_data);

  `ECRM_ASSERT_ALWAYS(a_reset_sweep, clk, $past(rst) |-> (state == ST_SWEEP && sweep_cnt == '0), "no clearing sweep after reset")
  `ECRM_ASSERT(a_query_no_write, clk, rst, (state == ST_EXEC && work.op == OP_QUERY) |-> !(row_we || col_we), "table written during query")
  `ECRM_ASSERT(a_query_result, clk, rst, (state == ST_EXEC && work.op == OP_QUERY && out_free) |=> m_tvalid, "query finished without result")

endmodule

`default_nettype wire

### src/edge_color_run_mask.sv
// top level of the edge colour run mask: front end, request queue, back end
// depends on ecrm_pkg, ecrm_front, ecrm_queue, ecrm_back and ecrm_ram
//
// channel   dir  handshake          payload
// config    in   cfg_we             cfg_index, cfg_data
// s (items) in   s_tvalid/s_tready  s_tdata, s_tuser
// m (mask)  out  m_tvalid/m_tready  m_tdata
//
// a load or query runs as a table read while idle, then a write or result in the exec state
// a clear runs a sweep over both tables, covering max(MAX_WIDTH, MAX_HEIGHT) = 1024 entries
// reset starts the same sweep; s_tready stays low while it runs
// loads that match the key or lie off the frame, and unknown function codes, are dropped in the front end
// the two-entry queue lets the front accept while a result waits on m_tready, until the queue is full
`default_nettype none

module edge_color_run_mask import ecrm_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [PIXEL_W-1:0]    cfg_data,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // pixel_value [31:0], col [41:32], row [51:42], zero [55:52]
  input  wire logic [S_TDATA_W-1:0]  s_tdata,
  // func [1:0]
  input  wire logic [FUNC_W-1:0]     s_tuser,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // mask_value [7:0]
  output logic [M_TDATA_W-1:0]       m_tdata
);

  logic q_push;
  req_t q_req;
  logic q_full;
  logic q_pop;
  logic head_valid;
  req_t head_req;
  logic sweeping;

  ecrm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .hold      (sweeping),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_req     (q_req)
  );

  ecrm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_req   (q_req),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  ecrm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_req   (head_req),
    .pop        (q_pop),
    .sweeping   (sweeping),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

endmodule

`default_nettype wire

### sim/edge_color_run_mask_test.sv
// self-checking testbench for edge_color_run_mask: frames of loads, queries and clears
// under several key colours, channel counts and handshake idling patterns
// depends on ecrm_pkg and the edge_color_run_mask rtl
`timescale 1ns / 100ps

module edge_color_run_mask_test;
  import ecrm_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 1100;    // covers a clearing sweep plus the pipeline
  localparam int QUIET_LIMIT  = 20000;
  localparam int PHASES       = 8;
  localparam int ITEMS        = 1750;

  // tracks the border bounds and queues the mask bytes each query should return
  class run_mask_scoreboard;
    logic [PIXEL_W-1:0]  key_color;
    logic [CH_CNT_W-1:0] channel_count;
    logic [COLF_W-1:0]   row_first [MAX_HEIGHT];
    logic [COL_AW-1:0]   row_last  [MAX_HEIGHT];
    logic [ROWF_W-1:0]   col_first [MAX_WIDTH];
    logic [ROW_AW-1:0]   col_last  [MAX_WIDTH];
    logic [MASK_W-1:0]   pending_masks [$];
    int                  errors;

    function new();
      key_color = '0;
      channel_count = CH_CNT_RESET;
      errors = 0;
      wipe_tables();
    endfunction

    function void wipe_tables();
      int i;
      for (i = 0; i < MAX_HEIGHT; i++) begin
        row_first[i] = COLF_W'(MAX_WIDTH);
        row_last[i] = '0;
      end
      for (i = 0; i < MAX_WIDTH; i++) begin
        col_first[i] = ROWF_W'(MAX_HEIGHT);
        col_last[i] = '0;
      end
    endfunction

    function void write_register(logic index, logic [PIXEL_W-1:0] value);
      if (index == REG_KEY_COLOR) begin
        key_color = value;
      end else begin
        channel_count = value[CH_CNT_W-1:0];
      end
    endfunction

    function logic [PIXEL_W-1:0] compared_bits();
      if (channel_count == 0) return '0;
      if (channel_count >= 4) return '1;
      return (32'd1 << (8 * channel_count)) - 32'd1;
    endfunction

    function void note_request(logic [FUNC_W-1:0] func, logic [PIXEL_W-1:0] pix,
                               logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
      logic [PIXEL_W-1:0] cmp;
      logic               in_frame;
      logic [MASK_W-1:0]  mask;
      cmp = compared_bits();
      in_frame = (int'(col) < MAX_WIDTH) && (int'(row) < MAX_HEIGHT);
      case (func)
        FUNC_CLEAR: wipe_tables();
        FUNC_LOAD: begin
          if (in_frame && ((pix & cmp) != (key_color & cmp))) begin
            if (col < row_first[row]) row_first[row] = COLF_W'(col);
            if (col > row_last[row])  row_last[row]  = col;
            if (row < col_first[col]) col_first[col] = ROWF_W'(row);
            if (row > col_last[col])  col_last[col]  = row;
          end
        end
        FUNC_QUERY: begin
          mask = MASK_OPAQUE;
          // transparent when a key-only run reaches an edge in the row or the column
          if (in_frame && (col < row_first[row] || col > row_last[row] ||
                           row < col_first[col] || row > col_last[col]))
            mask = MASK_CLEAR;
          pending_masks.push_back(mask);
        end
        default: ;
      endcase
    endfunction

    function void check_mask(logic [MASK_W-1:0] got);
      logic [MASK_W-1:0] want;
      if (pending_masks.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected mask result %0d", got);
      end else begin
        want = pending_masks.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mask mismatch: expected %0d, got %0d", want, got);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_we;
  logic                 cfg_index;
  logic [PIXEL_W-1:0]   cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata;
  logic [FUNC_W-1:0]    s_tuser;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  run_mask_scoreboard sb;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int items_sent = 0;
  int quiet_cycles = 0;

  edge_color_run_mask DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check, stall at random, watch for a hang
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (m_tvalid && m_tready) sb.check_mask(m_tdata);
    m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("edge_color_run_mask test failed");
      $finish;
    end
  end

  // valid stays high between back-to-back requests and only drops in a gap
  task automatic send_request(logic [FUNC_W-1:0] func, logic [PIXEL_W-1:0] pix,
                              logic [COORD_W-1:0] col, logic [COORD_W-1:0] row);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= {4'b0, row, col, pix};
    do @(posedge clk); while (!s_tready);
    sb.note_request(func, pix, col, row);
    if (func != FUNC_UNUSED) items_sent++;
  endtask

  task automatic settle();
    s_tvalid <= 1'b0;
    while (sb.pending_masks.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_config(logic [PIXEL_W-1:0] key, logic [CH_CNT_W-1:0] count);
    cfg_we <= 1'b1;
    cfg_index <= REG_KEY_COLOR;
    cfg_data <= key;
    sb.write_register(REG_KEY_COLOR, key);
    @(posedge clk);
    cfg_index <= REG_CHANNEL_COUNT;
    cfg_data <= PIXEL_W'(count);
    sb.write_register(REG_CHANNEL_COUNT, PIXEL_W'(count));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // key-coloured for key_pct percent of pixels; misses often touch a single channel only
  function automatic logic [PIXEL_W-1:0] frame_pixel(int key_pct);
    logic [PIXEL_W-1:0] pix;
    pix = sb.key_color;
    if ($urandom_range(99) < key_pct) begin
      if ($urandom_range(1)) pix[31:24] = 8'($urandom_range(255));
    end else if ($urandom_range(3) == 0) begin
      pix = $urandom;
    end else begin
      pix = pix ^ (PIXEL_W'($urandom_range(1, 255)) << (8 * $urandom_range(3)));
    end
    return pix;
  endfunction

  task automatic send_noise(int ox, int oy, int w, int h);
    case ($urandom_range(3))
      0: send_request(FUNC_UNUSED, $urandom, COORD_W'($urandom), COORD_W'($urandom));
      1: send_request(FUNC_LOAD, $urandom, COORD_W'($urandom), COORD_W'($urandom));
      2: send_request(FUNC_QUERY, $urandom, COORD_W'($urandom), COORD_W'($urandom));
      default: send_request(FUNC_QUERY, $urandom, COORD_W'(ox + $urandom_range(w - 1)),
                            COORD_W'(oy + $urandom_range(h - 1)));
    endcase
  endtask

  task automatic run_frame();
    int w, h, ox, oy, key_pct, x, y, n;
    w = $urandom_range(1, 8);
    h = $urandom_range(1, 8);
    // frames sit mostly in the top-left corner, sometimes against the far edges
    case ($urandom_range(3))
      0: ox = MAX_WIDTH - w;
      1: ox = $urandom_range(MAX_WIDTH - w);
      default: ox = 0;
    endcase
    case ($urandom_range(3))
      0: oy = MAX_HEIGHT - h;
      1: oy = $urandom_range(MAX_HEIGHT - h);
      default: oy = 0;
    endcase
    key_pct = $urandom_range(30, 90);
    send_request(FUNC_CLEAR, $urandom, COORD_W'($urandom), COORD_W'($urandom));
    for (y = 0; y < h; y++) begin
      for (x = 0; x < w; x++) begin
        send_request(FUNC_LOAD, frame_pixel(key_pct), COORD_W'(ox + x), COORD_W'(oy + y));
        if ($urandom_range(99) < 6) send_noise(ox, oy, w, h);
      end
    end
    // reloads only widen the bounds
    if ($urandom_range(4) == 0)
      send_request(FUNC_LOAD, frame_pixel(key_pct), COORD_W'(ox + $urandom_range(w - 1)),
                   COORD_W'(oy + $urandom_range(h - 1)));
    n = $urandom_range(6, 16);
    repeat (n) begin
      send_request(FUNC_QUERY, $urandom, COORD_W'(ox - 1 + $urandom_range(w + 1)),
                   COORD_W'(oy - 1 + $urandom_range(h + 1)));
    end
  endtask

  task automatic run_directed();
    send_request(FUNC_QUERY, '0, 10'd0, 10'd0);
    send_request(FUNC_QUERY, '1, 10'd1023, 10'd1023);
    // top byte lies outside the three compared channels
    send_request(FUNC_LOAD, 32'hFF00_0000, 10'd0, 10'd0);
    send_request(FUNC_QUERY, '0, 10'd0, 10'd0);
    send_request(FUNC_LOAD, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
    send_request(FUNC_QUERY, '0, 10'd1023, 10'd1023);
    send_request(FUNC_QUERY, '0, 10'd1022, 10'd1023);
    send_request(FUNC_LOAD, 32'h0, 10'd1023, 10'd1023);
    send_request(FUNC_QUERY, '0, 10'd1023, 10'd1023);
    send_request(FUNC_LOAD, 32'h0000_0001, 10'd0, 10'd1023);
    send_request(FUNC_LOAD, 32'h0001_0000, 10'd1023, 10'd0);
    send_request(FUNC_QUERY, '0, 10'd0, 10'd1023);
    send_request(FUNC_QUERY, '0, 10'd1023, 10'd0);
    send_request(FUNC_QUERY, '0, 10'd512, 10'd1023);
    send_request(FUNC_UNUSED, '1, 10'd1023, 10'd1023);
    send_request(FUNC_LOAD, 32'h0080_0000, 10'd512, 10'd1023);
    send_request(FUNC_QUERY, '0, 10'd512, 10'd1023);
    send_request(FUNC_CLEAR, '1, 10'd1023, 10'd1023);
    send_request(FUNC_QUERY, '0, 10'd1023, 10'd1023);
    send_request(FUNC_LOAD, 32'h0055_5555, 10'h2AA, 10'h155);
    send_request(FUNC_QUERY, '0, 10'h2AA, 10'h155);
    send_request(FUNC_QUERY, '0, 10'h155, 10'h2AA);
  endtask

  initial begin
    int p, target;
    sb = new();
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_COLOR;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_CLEAR;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    for (p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        settle();
        case (p)
          1: write_config(32'hFFFF_FFFF, 3'd4);
          2: write_config($urandom, 3'd1);
          3: write_config($urandom, 3'd0);
          4: write_config($urandom, 3'd7);
          5: write_config(32'h0, 3'd2);
          6: write_config($urandom, 3'd5);
          default: write_config($urandom, 3'd3);
        endcase
      end
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 78; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 78; end
        default: begin sender_idle_pct = 35; receiver_stall_pct = 35; end
      endcase
      if (p == 0) run_directed();
      target = items_sent + ITEMS / PHASES;
      while (items_sent < target) run_frame();
    end
    settle();
    if (sb.errors == 0 && sb.pending_masks.size() == 0) begin
      $display("edge_color_run_mask test passed");
    end else begin
      $display("edge_color_run_mask test failed");
    end
    $finish;
  end

endmodule
